>>> hdl/sphere_collision_depth_assert.svh
// Assertion macros for the sphere collision depth block.
// Used by sphere_collision_depth.sv; needs clk and rst in scope.
`ifndef SPHERE_COLLISION_DEPTH_ASSERT_SVH
`define SPHERE_COLLISION_DEPTH_ASSERT_SVH

// same-cycle implication
`define SCD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SCD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> hdl/scd_pkg.sv
// Shared types and constants for the sphere collision depth block.
// No dependencies.
`timescale 1ns / 1ps

package scd_pkg;

  localparam int SQRT_STEPS = 32;

  typedef struct packed {
    logic        vld;
    logic        far;
    logic [31:0] limit;
    logic [63:0] rem;
    logic [63:0] root;
  } scd_sq_t;

endpackage

>>> hdl/scd_dist.sv
// Front end: per-axis distance, squares and squared sum in three stages.
// Depends on scd_pkg.
`timescale 1ns / 1ps

module scd_dist (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  vld_in,
  input  logic                  cmd,
  input  logic signed [31:0]    own_x,
  input  logic signed [31:0]    own_y,
  input  logic signed [31:0]    own_z,
  input  logic signed [31:0]    other_x,
  input  logic signed [31:0]    other_y,
  input  logic signed [31:0]    other_z,
  input  logic [30:0]           extent_x,
  input  logic [30:0]           extent_y,
  input  logic [30:0]           extent_z,
  input  logic [30:0]           own_radius,
  output scd_pkg::scd_sq_t      sq_out
);

  logic signed [33:0] own_e [3];
  logic signed [33:0] oth_e [3];
  logic signed [33:0] ext_e [3];
  logic [32:0]        d_next [3];
  logic [31:0]        limit_next;

  logic               s1_vld;
  logic [32:0]        s1_d [3];
  logic [31:0]        s1_limit;

  logic               s2_vld;
  logic               s2_far;
  logic [63:0]        s2_sq [3];
  logic [31:0]        s2_limit;

  logic [65:0]        sum;

  always_comb begin
    logic signed [33:0] lo;
    logic signed [33:0] hi;
    logic signed [33:0] np;
    logic signed [33:0] df;
    own_e[0] = 34'(own_x);
    own_e[1] = 34'(own_y);
    own_e[2] = 34'(own_z);
    oth_e[0] = 34'(other_x);
    oth_e[1] = 34'(other_y);
    oth_e[2] = 34'(other_z);
    ext_e[0] = $signed({3'b000, extent_x});
    ext_e[1] = $signed({3'b000, extent_y});
    ext_e[2] = $signed({3'b000, extent_z});
    for (int i = 0; i < 3; i++) begin
      lo = oth_e[i] - ext_e[i];
      hi = oth_e[i] + ext_e[i];
      if (cmd) begin
        np = (own_e[i] < lo) ? lo : ((own_e[i] > hi) ? hi : own_e[i]);
      end else begin
        np = oth_e[i];
      end
      df = own_e[i] - np;
      d_next[i] = df[33] ? 33'(-df) : 33'(df);
    end
    limit_next = cmd ? {1'b0, own_radius} : ({1'b0, own_radius} + {1'b0, extent_x});
  end

  assign sum = {2'b00, s2_sq[0]} + {2'b00, s2_sq[1]} + {2'b00, s2_sq[2]};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld     <= 1'b0;
      s2_vld     <= 1'b0;
      sq_out.vld <= 1'b0;
    end else if (en) begin
      s1_vld     <= vld_in;
      s2_vld     <= s1_vld;
      sq_out.vld <= s2_vld;
    end
    if (en) begin
      s1_d     <= d_next;
      s1_limit <= limit_next;
      s2_far   <= s1_d[0][32] | s1_d[1][32] | s1_d[2][32];
      for (int i = 0; i < 3; i++) begin
        s2_sq[i] <= s1_d[i][31:0] * s1_d[i][31:0];
      end
      s2_limit      <= s1_limit;
      sq_out.far    <= s2_far | sum[65] | sum[64];
      sq_out.limit  <= s2_limit;
      sq_out.rem    <= sum[63:0];
      sq_out.root   <= '0;
    end
  end

endmodule

>>> hdl/scd_sqrt_step.sv
// One registered step of the bit-by-bit integer square root.
// Depends on scd_pkg.
`timescale 1ns / 1ps

module scd_sqrt_step (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic [63:0]      bitpos,
  input  scd_pkg::scd_sq_t sq_in,
  output scd_pkg::scd_sq_t sq_out
);

  logic [63:0] trial;
  logic [63:0] rem_next;
  logic [63:0] root_next;

  always_comb begin
    trial = sq_in.root + bitpos;
    if (sq_in.rem >= trial) begin
      rem_next  = sq_in.rem - trial;
      root_next = (sq_in.root >> 1) + bitpos;
    end else begin
      rem_next  = sq_in.rem;
      root_next = sq_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_out.vld <= 1'b0;
    end else if (en) begin
      sq_out.vld <= sq_in.vld;
    end
    if (en) begin
      sq_out.far   <= sq_in.far;
      sq_out.limit <= sq_in.limit;
      sq_out.rem   <= rem_next;
      sq_out.root  <= root_next;
    end
  end

endmodule

>>> hdl/sphere_collision_depth.sv
// Channel | handshake          | payload
// request | in_valid/in_ready  | cmd, own_*, other_*, extent_*
// result  | out_valid/out_ready| hit, depth
// config  | cfg_we             | cfg_data (own_radius)
// Pipeline: 3 distance/square/sum stages, 32 square root steps, output.
// One request per cycle while the output is not stalled; the pipeline advances as a whole.
// A stalled output register holds every stage; in_ready is low meanwhile.
// Synchronous reset clears valid bits and sets own_radius to 65536.
// Top level; depends on scd_pkg, scd_dist, scd_sqrt_step and the assert header.
`timescale 1ns / 1ps
`include "sphere_collision_depth_assert.svh"

module sphere_collision_depth (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic signed [31:0] own_x,
  input  logic signed [31:0] own_y,
  input  logic signed [31:0] own_z,
  input  logic signed [31:0] other_x,
  input  logic signed [31:0] other_y,
  input  logic signed [31:0] other_z,
  input  logic [30:0]        extent_x,
  input  logic [30:0]        extent_y,
  input  logic [30:0]        extent_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               hit,
  output logic [31:0]        depth,
  input  logic               cfg_we,
  input  logic [30:0]        cfg_data
);

  logic             en;
  logic [30:0]      own_radius;
  scd_pkg::scd_sq_t chain [scd_pkg::SQRT_STEPS + 1];
  scd_pkg::scd_sq_t last;
  logic             hit_next;

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;
  assign last     = chain[scd_pkg::SQRT_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      own_radius <= 31'd65536;
    end else if (cfg_we) begin
      own_radius <= cfg_data;
    end
  end

  scd_dist u_dist (
    .clk(clk), .rst(rst), .en(en), .vld_in(in_valid), .cmd(cmd),
    .own_x(own_x), .own_y(own_y), .own_z(own_z),
    .other_x(other_x), .other_y(other_y), .other_z(other_z),
    .extent_x(extent_x), .extent_y(extent_y), .extent_z(extent_z),
    .own_radius(own_radius), .sq_out(chain[0])
  );

  for (genvar k = 0; k < scd_pkg::SQRT_STEPS; k++) begin : g_sqrt
    scd_sqrt_step u_step (
      .clk(clk), .rst(rst), .en(en),
      .bitpos(64'(1) << (62 - 2 * k)),
      .sq_in(chain[k]), .sq_out(chain[k + 1])
    );
  end

  assign hit_next = ~last.far && (last.root[31:0] < last.limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= last.vld;
    end
    if (en) begin
      hit   <= hit_next;
      depth <= hit_next ? (last.limit - last.root[31:0]) : '0;
    end
  end

  `SCD_ASSERT_NOW(a_miss_zero, out_valid && !hit, depth == 32'd0)
  `SCD_ASSERT_NOW(a_hit_depth, out_valid && hit, depth != 32'd0)
  `SCD_ASSERT_NEXT(a_far_miss, en && last.vld && last.far, out_valid && !hit)

endmodule
